// File: hdl/b64e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared constants, types and helpers for the custom-alphabet Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int MAX_OUTPUT  = 4096;
  localparam int CNT_W       = $clog2(MAX_OUTPUT);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_OUTPUT - 1);

  localparam int OUT_COUNT_W = 12;
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = 6;
  localparam int NUM_WORDS   = 8;
  localparam int WORD_W      = 64;
  localparam int CFG_IDX_W   = $clog2(NUM_WORDS);
  localparam int HELD_W      = 4;
  localparam int HELD_CNT_W  = 3;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

  typedef enum logic {
    ACT_DATA = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  // One accepted item, already split into 6-bit alphabet indexes
  typedef struct packed {
    logic             is_end;
    logic             flush;   // end item with leftover bits to emit
    logic             two;     // data item producing two characters
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
  } item_t;

  typedef logic [NUM_WORDS*WORD_W-1:0] alphabet_t;

  function automatic logic [CHAR_W-1:0] alpha_lookup(input alphabet_t a,
                                                     input logic [IDX_W-1:0] k);
    return a[{k, 3'b000} +: CHAR_W];
  endfunction

endpackage
`default_nettype wire

// File: hdl/b64e_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_cfg
// Alphabet register file: eight 64-bit words, eight characters per word.
// ----------------------------------------------------------------------------
module b64e_cfg
  import b64e_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output alphabet_t                 alphabet
);

  logic [WORD_W-1:0] words_r [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else if (cfg_we) begin
      words_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WORDS; i++) begin
      alphabet[i*WORD_W +: WORD_W] = words_r[i];
    end
  end

endmodule
`default_nettype wire

// File: hdl/b64e_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pack
// Input register and bit packer: joins each byte to the leftover bits and
// registers the resulting 6-bit groups for the emit stage.
// ----------------------------------------------------------------------------
module b64e_pack
  import b64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_data_byte,
  output logic             item_valid,
  output item_t            item,
  input  wire logic        item_done
);

  logic [HELD_W-1:0]     held_bits_r, held_bits_nxt;
  logic [HELD_CNT_W-1:0] held_cnt_r, held_cnt_nxt;
  logic                  item_valid_r, item_valid_nxt;
  item_t                 item_r, item_nxt;
  logic                  accept;

  assign in_ready = !item_valid_r || item_done;
  assign accept   = in_valid && in_ready;

  always_comb begin
    item_nxt       = '0;
    held_bits_nxt  = held_bits_r;
    held_cnt_nxt   = held_cnt_r;
    item_valid_nxt = item_valid_r && !item_done;

    if (accept) begin
      item_valid_nxt = 1'b1;
      if (action_t'(in_action) == ACT_END) begin
        item_nxt.is_end = 1'b1;
        item_nxt.flush  = (held_cnt_r != '0);
        // leftover bits go to the top of the group, zero filled below
        item_nxt.idx0   = (held_cnt_r == HELD_CNT_W'(2)) ? {held_bits_r[1:0], 4'b0000}
                                                         : {held_bits_r, 2'b00};
        held_bits_nxt   = '0;
        held_cnt_nxt    = '0;
      end else begin
        case (held_cnt_r)
          HELD_CNT_W'(0): begin
            item_nxt.idx0 = in_data_byte[7:2];
            held_bits_nxt = {2'b00, in_data_byte[1:0]};
            held_cnt_nxt  = HELD_CNT_W'(2);
          end
          HELD_CNT_W'(2): begin
            item_nxt.idx0 = {held_bits_r[1:0], in_data_byte[7:4]};
            held_bits_nxt = in_data_byte[3:0];
            held_cnt_nxt  = HELD_CNT_W'(4);
          end
          default: begin
            item_nxt.two  = 1'b1;
            item_nxt.idx0 = {held_bits_r, in_data_byte[7:6]};
            item_nxt.idx1 = in_data_byte[5:0];
            held_bits_nxt = '0;
            held_cnt_nxt  = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bits_r  <= '0;
      held_cnt_r   <= '0;
      item_valid_r <= 1'b0;
    end else begin
      held_bits_r  <= held_bits_nxt;
      held_cnt_r   <= held_cnt_nxt;
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// File: hdl/b64e_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_emit
// Emit stage: looks up one character per cycle for the held item while the
// result register can load, applies the output limit and padding, and drives
// the result register.
module b64e_emit
  import b64e_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   item_valid,
  input  wire item_t                  item,
  output logic                        item_done,
  input  wire alphabet_t              alphabet,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CHAR_W-1:0]           out_char,
  output logic                        out_run_last,
  output logic [OUT_COUNT_W-1:0]      out_count
);

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [1:0]             n_r, n_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_run_last_r;
  logic [OUT_COUNT_W-1:0] out_count_r;

  logic                   cur_flush;
  logic [IDX_W-1:0]       cur_idx;
  logic [CHAR_W-1:0]      cur_char;
  logic                   has_char;
  logic [CNT_W-1:0]       cnt_inc;
  logic [1:0]             n_inc;
  logic                   more;
  logic                   out_load;
  logic                   emit;

  always_comb begin
    cur_flush = item.is_end && item.flush && (n_r == 2'd0);
    cur_idx   = (n_r == 2'd0) ? item.idx0 : item.idx1;
    cur_char  = (item.is_end && !cur_flush) ? PAD_CHAR : alpha_lookup(alphabet, cur_idx);
    has_char  = (count_r != CNT_LIMIT) &&
                (!item.is_end || cur_flush || (count_r[1:0] != 2'b00));
    cnt_inc   = count_r + CNT_W'(1);
    n_inc     = n_r + 2'd1;
    // another character from this item after the one going out now
    more      = (cnt_inc != CNT_LIMIT) &&
                (item.is_end ? ((cnt_inc[1:0] != 2'b00) && (n_inc != 2'd3))
                             : (item.two && (n_inc == 2'd1)));
    out_load  = !out_valid_r || out_ready;
    emit      = item_valid && has_char && out_load;
    item_done = item_valid && (!has_char || (out_load && !more));

    count_nxt = count_r;
    if (item_done && item.is_end) begin
      count_nxt = '0;
    end else if (emit) begin
      count_nxt = cnt_inc;
    end

    n_nxt = n_r;
    if (item_done) begin
      n_nxt = 2'd0;
    end else if (emit) begin
      n_nxt = n_inc;
    end

    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      n_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r     <= cur_char;
      out_run_last_r <= !more;
      out_count_r    <= OUT_COUNT_W'(cnt_inc);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_run_last = out_run_last_r;
  assign out_count    = out_count_r;

  // a data item never produces more than two characters
  a_data_two_max: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && !item.is_end) |-> (n_r <= 2'd1))
    else $error("data item emitting a third character");

  // an end item leaves the character count cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (item_done && item.is_end) |=> (count_r == '0))
    else $error("count not cleared after end item");

  // per-item counter is idle between items
  a_n_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |-> (n_r == 2'd0))
    else $error("per-item counter not idle");

  // count moves only by one step or back to zero
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> ((count_r == $past(count_r) + CNT_W'(1)) || (count_r == '0)))
    else $error("count jumped");

endmodule
`default_nettype wire

// File: hdl/base64_encoder_custom_alphabet.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_encoder_custom_alphabet
// Streaming Base64 encoder with a 64-character alphabet held in eight
// configuration words.
// ----------------------------------------------------------------------------
// Each accepted item passes through an input register (bit packing) and an
// emit stage that makes one character per cycle, when out_ready allows, into
// the result register, so throughput is set by that single result port: a data
// byte yields one or two characters, an end item one to three, and an item may
// yield none. The first result of an item passes the input register, then the
// result register. The input register, when empty, takes a new item while the
// previous result waits on out_ready. Characters beyond MAX_OUTPUT-1 in a
// message are dropped; out_run_last marks the last character caused by an item.
// The user writes alphabet words through cfg_we/cfg_index/cfg_data while idle; the block does not enforce it.
module base64_encoder_custom_alphabet
  import b64e_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_action,
  input  wire logic [7:0]             in_data_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [CHAR_W-1:0]           out_char,
  output logic                        out_run_last,
  output logic [OUT_COUNT_W-1:0]      out_count
);

  alphabet_t alphabet;
  logic      item_valid;
  item_t     item;
  logic      item_done;

  b64e_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alphabet  (alphabet)
  );

  b64e_pack u_pack (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .item_valid   (item_valid),
    .item         (item),
    .item_done    (item_done)
  );

  b64e_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item         (item),
    .item_done    (item_done),
    .alphabet     (alphabet),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_count    (out_count)
  );

endmodule
`default_nettype wire
